@@ rtl/etev_pkg.sv @@
// etev_pkg: shared widths, command codes and unit request types for the
// encoder tick extension and velocity block. No dependencies.
package etev_pkg;

  localparam int MUL_A_W   = 116;
  localparam int MUL_B_W   = 52;
  localparam int DIV_N_W   = 86;
  localparam int DIV_D_W   = 20;
  localparam int DIV_CNT_W = 7;

  localparam logic CMD_WRAP   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] n;
    logic [DIV_D_W-1:0] d;
  } div_req_t;

endpackage

@@ rtl/encoder_tick_extend_velocity.sv @@
// Encoder tick extension and velocity: a wrap event updates the wrap count and gives no result.
// A sample with zero period passes straight to the load state, which takes its result into the
// output register once that is free. Any other sample goes through one shared shift-add
// multiplier (one multiplier bit per cycle, up to the highest set bit) and one shared restoring
// divider (86 quotient bits): five products and three quotients, or only the tick-total product
// when pulses_per_rev is zero. One sample is worked on at a time; a finished result waits in the
// output register while the next request is taken.
// Depends on etev_pkg, etev_mul and etev_div.
module encoder_tick_extend_velocity #(
  parameter int COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic        count_down,
  input  logic [31:0] counter_value,
  input  logic        wrap_pending,
  input  logic [19:0] period_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] tick_total,
  output logic signed [31:0] velocity_um_s,
  output logic signed [63:0] distance_um,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import etev_pkg::*;

  localparam logic [7:0]  CFG_COUNTER_TOP = 8'd0;
  localparam logic [7:0]  CFG_PPR         = 8'd1;
  localparam logic [7:0]  CFG_DIAMETER    = 8'd2;
  localparam logic [7:0]  CFG_INVERT      = 8'd3;
  localparam logic [31:0] PI_Q30          = 32'd3373259426;
  localparam logic [19:0] US_PER_S        = 20'd1000000;
  localparam int          COEF_W          = 52;
  localparam int          Q_SHIFT         = 30;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TOTAL, ST_COEF, ST_DD_MUL, ST_DD_DIV,
    ST_V_MUL, ST_V_DIV, ST_D_MUL, ST_D_DIV, ST_LOAD
  } state_t;

  function automatic logic [63:0] sat64(input logic [DIV_N_W-1:0] q, input logic neg);
    logic        over;
    logic [63:0] mag;
    over = neg ? (q > (DIV_N_W'(1) << 63)) : (q[DIV_N_W-1:63] != '0);
    mag  = over ? (neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) : q[63:0];
    return neg ? (64'd0 - mag) : mag;
  endfunction

  function automatic logic [31:0] sat32(input logic [DIV_N_W-1:0] q, input logic neg);
    logic        over;
    logic [31:0] mag;
    over = neg ? (q > DIV_N_W'(32'h8000_0000)) : (q > DIV_N_W'(32'h7FFF_FFFF));
    mag  = over ? (neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : q[31:0];
    return neg ? (32'd0 - mag) : mag;
  endfunction

  state_t state;

  logic [31:0] counter_top;
  logic [15:0] pulses_per_rev;
  logic [19:0] wheel_diameter_um;
  logic        invert_direction;

  logic [31:0] wrap_count;
  logic [63:0] previous_ticks;
  logic [63:0] held_distance;

  logic [COUNTER_BITS-1:0] lat_cnt;
  logic [19:0]             lat_period;
  logic [63:0]             total_r;
  logic [63:0]             cur_r;
  logic [63:0]             delta_r;
  logic [COEF_W-1:0]       coef;
  logic                    neg_r;
  logic [31:0]             res_vel;
  logic [63:0]             res_dist;

  mul_req_t           mul_req;
  logic               mul_done;
  logic [MUL_A_W-1:0] mul_p;
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_N_W-1:0] div_q;

  logic [63:0]           wraps_sx;
  logic [63:0]           wraps_adj;
  logic [COUNTER_BITS:0] top_plus;
  logic [63:0]           total_c;
  logic [63:0]           cur_c;
  logic [63:0]           prev_c;
  logic [63:0]           delta_c;
  logic [63:0]           sat_c;
  logic [63:0]           sat_mag;
  logic [63:0]           delta_mag;
  logic [63:0]           cur_mag;

  etev_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_p)
  );

  etev_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign wraps_sx  = {{32{wrap_count[31]}}, wrap_count};
  assign wraps_adj = !wrap_pending ? wraps_sx :
                     (count_down ? (wraps_sx - 64'd1) : (wraps_sx + 64'd1));
  assign top_plus  = {1'b0, counter_top[COUNTER_BITS-1:0]} + 1'b1;
  assign total_c   = mul_p[63:0] + 64'(lat_cnt);
  assign cur_c     = invert_direction ? (64'd0 - total_c) : total_c;
  assign prev_c    = invert_direction ? (64'd0 - previous_ticks) : previous_ticks;
  assign delta_c   = cur_c - prev_c;
  assign sat_c     = sat64(div_q, neg_r);
  assign sat_mag   = sat_c[63] ? (64'd0 - sat_c) : sat_c;
  assign delta_mag = delta_r[63] ? (64'd0 - delta_r) : delta_r;
  assign cur_mag   = cur_r[63] ? (64'd0 - cur_r) : cur_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      counter_top       <= 32'd65535;
      pulses_per_rev    <= '0;
      wheel_diameter_um <= '0;
      invert_direction  <= 1'b0;
      wrap_count        <= '0;
      previous_ticks    <= '0;
      held_distance     <= '0;
      mul_req.start     <= 1'b0;
      div_req.start     <= 1'b0;
    end else begin
      if (mul_req.start) begin
        mul_req.start <= 1'b0;
      end
      if (div_req.start) begin
        div_req.start <= 1'b0;
      end
      if (out_valid && out_ready && state != ST_LOAD) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_COUNTER_TOP: counter_top       <= cfg_data;
          CFG_PPR:         pulses_per_rev    <= cfg_data[15:0];
          CFG_DIAMETER:    wheel_diameter_um <= cfg_data[19:0];
          CFG_INVERT:      invert_direction  <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (cmd == CMD_WRAP) begin
              wrap_count <= count_down ? (wrap_count - 32'd1) : (wrap_count + 32'd1);
            end else if (period_us == '0) begin
              total_r  <= previous_ticks;
              res_vel  <= '0;
              res_dist <= held_distance;
              state    <= ST_LOAD;
            end else begin
              lat_cnt       <= counter_value[COUNTER_BITS-1:0];
              lat_period    <= period_us;
              mul_req.start <= 1'b1;
              mul_req.a     <= MUL_A_W'(wraps_adj);
              mul_req.b     <= MUL_B_W'(top_plus);
              state         <= ST_TOTAL;
            end
          end
        end
        ST_TOTAL: begin
          if (mul_done) begin
            total_r <= total_c;
            cur_r   <= cur_c;
            delta_r <= delta_c;
            if (pulses_per_rev == '0) begin
              res_vel        <= '0;
              res_dist       <= '0;
              held_distance  <= '0;
              previous_ticks <= total_c;
              state          <= ST_LOAD;
            end else begin
              mul_req.start <= 1'b1;
              mul_req.a     <= MUL_A_W'(PI_Q30);
              mul_req.b     <= MUL_B_W'(wheel_diameter_um);
              state         <= ST_COEF;
            end
          end
        end
        ST_COEF: begin
          if (mul_done) begin
            coef          <= mul_p[COEF_W-1:0];
            neg_r         <= delta_r[63];
            mul_req.start <= 1'b1;
            mul_req.a     <= MUL_A_W'(delta_mag);
            mul_req.b     <= mul_p[COEF_W-1:0];
            state         <= ST_DD_MUL;
          end
        end
        ST_DD_MUL: begin
          if (mul_done) begin
            div_req.start <= 1'b1;
            div_req.n     <= mul_p[MUL_A_W-1:Q_SHIFT];
            div_req.d     <= DIV_D_W'(pulses_per_rev);
            state         <= ST_DD_DIV;
          end
        end
        ST_DD_DIV: begin
          if (div_done) begin
            neg_r         <= sat_c[63];
            mul_req.start <= 1'b1;
            mul_req.a     <= MUL_A_W'(sat_mag);
            mul_req.b     <= MUL_B_W'(US_PER_S);
            state         <= ST_V_MUL;
          end
        end
        ST_V_MUL: begin
          if (mul_done) begin
            div_req.start <= 1'b1;
            div_req.n     <= mul_p[DIV_N_W-1:0];
            div_req.d     <= lat_period;
            state         <= ST_V_DIV;
          end
        end
        ST_V_DIV: begin
          if (div_done) begin
            res_vel       <= sat32(div_q, neg_r);
            neg_r         <= cur_r[63];
            mul_req.start <= 1'b1;
            mul_req.a     <= MUL_A_W'(cur_mag);
            mul_req.b     <= coef;
            state         <= ST_D_MUL;
          end
        end
        ST_D_MUL: begin
          if (mul_done) begin
            div_req.start <= 1'b1;
            div_req.n     <= mul_p[MUL_A_W-1:Q_SHIFT];
            div_req.d     <= DIV_D_W'(pulses_per_rev);
            state         <= ST_D_DIV;
          end
        end
        ST_D_DIV: begin
          if (div_done) begin
            res_dist       <= sat_c;
            held_distance  <= sat_c;
            previous_ticks <= total_r;
            state          <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (!out_valid || out_ready) begin
            tick_total    <= total_r;
            velocity_um_s <= res_vel;
            distance_um   <= res_dist;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/etev_mul.sv @@
// etev_mul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on etev_pkg.
module etev_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  etev_pkg::mul_req_t           req,
  output logic                         done,
  output logic [etev_pkg::MUL_A_W-1:0] product
);
  import etev_pkg::*;

  logic [MUL_A_W-1:0] a;
  logic [MUL_B_W-1:0] b;
  logic [MUL_A_W-1:0] acc;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a    <= req.a;
        b    <= req.b;
        acc  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (b == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (b[0]) begin
            acc <= acc + a;
          end
          a <= a << 1;
          b <= b >> 1;
        end
      end
    end
  end

  assign product = acc;

endmodule

@@ rtl/etev_div.sv @@
// etev_div: restoring divider, one quotient bit per cycle.
// Depends on etev_pkg.
module etev_div (
  input  logic                         clk,
  input  logic                         rst,
  input  etev_pkg::div_req_t           req,
  output logic                         done,
  output logic [etev_pkg::DIV_N_W-1:0] quotient
);
  import etev_pkg::*;

  logic [DIV_N_W-1:0]   n;
  logic [DIV_D_W-1:0]   d;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;
  logic [DIV_D_W:0]     rem_sh;
  logic                 ge;
  logic [DIV_D_W:0]     diff;

  assign rem_sh = {rem, n[DIV_N_W-1]};
  assign ge     = rem_sh >= {1'b0, d};
  assign diff   = rem_sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        n     <= req.n;
        d     <= req.d;
        rem   <= '0;
        count <= DIV_CNT_W'(DIV_N_W - 1);
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        n   <= {n[DIV_N_W-2:0], ge};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  assign quotient = n;

endmodule

@@ rtl/etev_checker.sv @@
// etev_checker: port-level checks for encoder_tick_extend_velocity, with its bind.
// Depends on etev_pkg.
module etev_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [63:0] tick_total,
  input logic signed [31:0] velocity_um_s,
  input logic signed [63:0] distance_um
);
  import etev_pkg::*;

  // reset leaves no result and an open input
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("state after reset wrong");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tick_total)
      && $stable(velocity_um_s) && $stable(distance_um))
    else $error("stalled result changed");

  // a sample request closes the input
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_SAMPLE |=> !in_ready)
    else $error("input open right after a sample");

  // a wrap event leaves the input open
  a_wrap_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_WRAP |=> in_ready)
    else $error("input closed after a wrap event");

endmodule

bind encoder_tick_extend_velocity etev_checker u_etev_checker (.*);

@@ sim/encoder_tick_extend_velocity_tb.sv @@
// encoder_tick_extend_velocity_tb: self-checking bench for the encoder tick extension and
// velocity block; predicts ticks, velocity and distance per sample and drives both channels
// with random gaps and stalls. Depends on etev_pkg and encoder_tick_extend_velocity.
module encoder_tick_extend_velocity_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etev_pkg::*;

  localparam int CNT_BITS = 32;
  localparam logic [31:0] CNT_MASK = 32'((64'd1 << CNT_BITS) - 64'd1);
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic [7:0] REG_COUNTER_TOP    = 8'd0;
  localparam logic [7:0] REG_PULSES_PER_REV = 8'd1;
  localparam logic [7:0] REG_WHEEL_DIAMETER = 8'd2;
  localparam logic [7:0] REG_INVERT_DIR     = 8'd3;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [63:0] total;
    logic [31:0] vel;
    logic [63:0] distance;
  } odometry_t;

  class odometry_board_t;
    odometry_t expected_q[$];
    logic [31:0] top_r;
    logic [15:0] ppr_r;
    logic [19:0] diam_r;
    logic        inv_r;
    logic [31:0] wraps_r;
    logic [63:0] prev_ticks;
    logic [63:0] held_dist;
    int errors, samples, wrap_events, vel_sats, zero_periods, cfg_writes;

    function new();
      top_r = 32'd65535;
      ppr_r = '0;
      diam_r = '0;
      inv_r = 1'b0;
      wraps_r = '0;
      prev_ticks = '0;
      held_dist = '0;
      errors = 0;
      samples = 0;
      wrap_events = 0;
      vel_sats = 0;
      zero_periods = 0;
      cfg_writes = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      cfg_writes++;
      case (idx)
        REG_COUNTER_TOP:    top_r = data;
        REG_PULSES_PER_REV: ppr_r = data[15:0];
        REG_WHEEL_DIAMETER: diam_r = data[19:0];
        REG_INVERT_DIR:     inv_r = data[0];
        default: ;
      endcase
    endfunction

    // signed distance in um of a signed tick count
    function logic [63:0] ticks_um(logic [63:0] t);
      logic         neg;
      logic [63:0]  mag, diam_pi;
      logic [127:0] q, cap;
      neg = t[63];
      mag = neg ? (64'd0 - t) : t;
      diam_pi = {44'd0, diam_r} * PI_Q30;
      q = ({64'd0, mag} * {64'd0, diam_pi}) / ({112'd0, ppr_r} << 30);
      cap = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
      if (q > cap) q = cap;
      return neg ? (64'd0 - q[63:0]) : q[63:0];
    endfunction

    function void take_request(logic c, logic down, logic [31:0] cnt, logic pend,
                               logic [19:0] per);
      odometry_t    e;
      logic [63:0]  wraps, span, total, cur, prev, dd, mag;
      logic [127:0] q, cap;
      logic         neg;
      if (c == CMD_WRAP) begin
        wraps_r = down ? wraps_r - 32'd1 : wraps_r + 32'd1;
        wrap_events++;
        return;
      end
      samples++;
      if (per == '0) begin
        zero_periods++;
        e.total = prev_ticks;
        e.vel = '0;
        e.distance = held_dist;
        expected_q.push_back(e);
        return;
      end
      wraps = {{32{wraps_r[31]}}, wraps_r};
      if (pend) wraps = down ? wraps - 64'd1 : wraps + 64'd1;
      span = {32'd0, top_r & CNT_MASK} + 64'd1;
      total = wraps * span + {32'd0, cnt & CNT_MASK};
      cur = inv_r ? (64'd0 - total) : total;
      prev = inv_r ? (64'd0 - prev_ticks) : prev_ticks;
      e.total = total;
      if (ppr_r != '0) begin
        dd = ticks_um(cur - prev);
        neg = dd[63];
        mag = neg ? (64'd0 - dd) : dd;
        q = ({64'd0, mag} * 128'd1000000) / {108'd0, per};
        cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > cap) begin
          q = cap;
          vel_sats++;
        end
        e.vel = neg ? (32'd0 - q[31:0]) : q[31:0];
        e.distance = ticks_um(cur);
      end else begin
        e.vel = '0;
        e.distance = '0;
      end
      held_dist = e.distance;
      prev_ticks = total;
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [63:0] tt, logic [31:0] v, logic [63:0] d);
      odometry_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no sample waiting, total %0d velocity %0d distance %0d",
                 $time, $signed(tt), $signed(v), $signed(d));
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (tt !== e.total) begin
        $display("%0t: tick_total expected %0d actual %0d", $time, $signed(e.total),
                 $signed(tt));
        errors++;
      end
      if (v !== e.vel) begin
        $display("%0t: velocity_um_s expected %0d actual %0d", $time, $signed(e.vel),
                 $signed(v));
        errors++;
      end
      if (d !== e.distance) begin
        $display("%0t: distance_um expected %0d actual %0d", $time, $signed(e.distance),
                 $signed(d));
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready;
  logic cmd, count_down, wrap_pending;
  logic [31:0] counter_value;
  logic [19:0] period_us;
  logic out_valid, out_ready;
  logic signed [63:0] tick_total;
  logic signed [31:0] velocity_um_s;
  logic signed [63:0] distance_um;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_index;
  logic [31:0] cfg_data;

  odometry_board_t board = new();
  int results_seen = 0;
  int holds_taken = 0;
  int stall_cycles = 0;
  int phases = 0;
  logic no_gaps = 1'b0;
  logic [31:0] last_cv = '0;

  encoder_tick_extend_velocity #(.COUNTER_BITS(CNT_BITS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .count_down(count_down), .counter_value(counter_value),
    .wrap_pending(wrap_pending), .period_us(period_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .tick_total(tick_total), .velocity_um_s(velocity_um_s), .distance_um(distance_um),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        board.take_request(cmd, count_down, counter_value, wrap_pending, period_us);
      if (out_valid && out_ready) begin
        board.check_result(tick_total, velocity_um_s, distance_um);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("** encoder_tick_extend_velocity: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random stalls, plus two long hold-offs to back up the input
  initial begin
    int len;
    int r;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_taken < 2 && results_seen >= (holds_taken == 0 ? 100 : 300)) begin
        holds_taken++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 200);
        end else if (r < 75) begin
          out_ready <= 1'($urandom_range(0, 1));
          len = $urandom_range(1, 4);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 20);
        end else begin
          out_ready <= 1'b0;
          len = $urandom_range(100, 600);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  task automatic request_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 20);
    else n = $urandom_range(50, 200);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic c, input logic down, input logic [31:0] cv,
                           input logic pend, input logic [19:0] per);
    in_valid <= 1'b1;
    cmd <= c;
    count_down <= down;
    counter_value <= cv;
    wrap_pending <= pend;
    period_us <= per;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    request_gap();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // registers change only with the block drained; also pokes an unmapped index
  task automatic program_regs(input logic [31:0] top, input logic [15:0] ppr,
                              input logic [19:0] diam, input logic inv);
    logic [31:0] junk;
    drain();
    junk = $urandom;
    write_cfg(8'($urandom_range(4, 255)), $urandom);
    write_cfg(REG_COUNTER_TOP, top);
    write_cfg(REG_PULSES_PER_REV, {junk[31:16], ppr});
    write_cfg(REG_WHEEL_DIAMETER, {junk[31:20], diam});
    write_cfg(REG_INVERT_DIR, {junk[31:1], inv});
    cfg_valid <= 1'b0;
    phases++;
  endtask

  task automatic random_config();
    logic [31:0] top;
    logic [15:0] ppr;
    logic [19:0] diam;
    case ($urandom_range(0, 5))
      0: top = 32'd0;
      1: top = 32'hFFFF_FFFF;
      2: top = 32'd65535;
      3: top = $urandom_range(1, 1000);
      4: top = $urandom;
      default: top = $urandom_range(1, 100000);
    endcase
    case ($urandom_range(0, 5))
      0: ppr = 16'd0;
      1: ppr = 16'd1;
      2: ppr = 16'hFFFF;
      3: ppr = 16'($urandom);
      default: ppr = 16'($urandom_range(1, 4096));
    endcase
    case ($urandom_range(0, 4))
      0: diam = 20'd0;
      1: diam = 20'd1000000;
      2: diam = 20'hFFFFF;
      default: diam = 20'($urandom_range(1, 1000000));
    endcase
    program_regs(top, ppr, diam, 1'($urandom_range(0, 1)));
  endtask

  task automatic random_requests(input int n);
    int k;
    int r;
    int burst_left;
    logic dir;
    logic [31:0] cv;
    logic [19:0] per;
    burst_left = 0;
    dir = 1'($urandom_range(0, 1));
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (burst_left > 0) begin
        burst_left--;
        send_item(CMD_WRAP, dir, $urandom, 1'($urandom_range(0, 1)), 20'($urandom));
      end else if (r < 60) begin
        r = $urandom_range(0, 99);
        if (r < 65) cv = last_cv + 32'($urandom_range(0, 2000)) - 32'd1000;
        else if (r < 80) cv = $urandom_range(0, board.top_r);
        else cv = $urandom;
        last_cv = cv;
        r = $urandom_range(0, 99);
        if (r < 5) per = 20'd0;
        else if (r < 12) per = 20'($urandom);
        else if (r < 20) per = 20'($urandom_range(1, 20));
        else per = 20'($urandom_range(1000, 1000000));
        send_item(CMD_SAMPLE,
                  $urandom_range(0, 99) < 80 ? dir : 1'($urandom_range(0, 1)),
                  cv, $urandom_range(0, 99) < 15, per);
      end else if (r < 65) begin
        burst_left = $urandom_range(5, 40);
      end else begin
        send_item(CMD_WRAP, $urandom_range(0, 99) < 80 ? dir : 1'($urandom_range(0, 1)),
                  $urandom, 1'($urandom_range(0, 1)), 20'($urandom));
      end
    end
  endtask

  initial begin
    int p;
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_WRAP;
    count_down <= 1'b0;
    counter_value <= '0;
    wrap_pending <= 1'b0;
    period_us <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: ppr zero
    send_item(CMD_SAMPLE, 1'b0, 32'd100, 1'b0, 20'd50);
    send_item(CMD_WRAP, 1'b0, 32'd0, 1'b0, 20'd0);
    send_item(CMD_SAMPLE, 1'b0, 32'd7, 1'b1, 20'd1000);

    program_regs(32'd999, 16'd1024, 20'd65000, 1'b0);
    send_item(CMD_WRAP, 1'b0, 32'd0, 1'b0, 20'd0);
    send_item(CMD_WRAP, 1'b1, 32'd0, 1'b0, 20'd0);
    send_item(CMD_SAMPLE, 1'b0, 32'd0, 1'b0, 20'd1000000);
    send_item(CMD_SAMPLE, 1'b0, 32'd999, 1'b0, 20'd1);
    send_item(CMD_SAMPLE, 1'b0, 32'd5, 1'b0, 20'd0);
    send_item(CMD_SAMPLE, 1'b0, 32'd3, 1'b1, 20'hFFFFF);
    send_item(CMD_SAMPLE, 1'b1, 32'd998, 1'b1, 20'd2000);
    send_item(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF, 1'b0, 20'd500);
    repeat (3) send_item(CMD_WRAP, 1'b1, 32'd0, 1'b0, 20'd0);
    send_item(CMD_SAMPLE, 1'b0, 32'd10, 1'b0, 20'd100000);

    program_regs(32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 1'b1);
    send_item(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF, 1'b0, 20'd1);
    send_item(CMD_WRAP, 1'b1, 32'd0, 1'b0, 20'd0);
    send_item(CMD_SAMPLE, 1'b1, 32'd0, 1'b1, 20'hFFFFF);
    send_item(CMD_SAMPLE, 1'b0, 32'h8000_0000, 1'b0, 20'd0);

    program_regs(32'd0, 16'd1, 20'd1000000, 1'b0);
    send_item(CMD_WRAP, 1'b0, 32'd0, 1'b0, 20'd0);
    send_item(CMD_SAMPLE, 1'b0, 32'd0, 1'b0, 20'd1);
    send_item(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF, 1'b0, 20'd1000000);
    send_item(CMD_SAMPLE, 1'b0, 32'd1, 1'b1, 20'd3);

    for (p = 0; p < 8; p++) begin
      random_config();
      no_gaps = (p % 3 == 1);
      random_requests(109);
    end
    no_gaps = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d samples (%0d zero period, %0d saturated velocity), %0d wrap events",
             board.samples, board.zero_periods, board.vel_sats, board.wrap_events);
    $display("%0d register writes over %0d settings, %0d long result hold-offs",
             board.cfg_writes, phases + 1, holds_taken);
    if (board.errors == 0) begin
      $display("** encoder_tick_extend_velocity: PASSED **");
    end else begin
      $display("** encoder_tick_extend_velocity: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/etev_pkg.sv
rtl/etev_mul.sv
rtl/etev_div.sv
rtl/encoder_tick_extend_velocity.sv
rtl/etev_checker.sv
sim/encoder_tick_extend_velocity_tb.sv
